[hw/rtl/hpv_pkg.sv]
// Shared types, constants and the arctangent table for the heading/pitch block.
`timescale 1ns / 1ps
package hpv_pkg;
    localparam int MaxStages = 32;
    localparam logic signed [31:0] PI_Q28      = 32'sd843314857;
    localparam logic signed [31:0] PI_DIV_2_Q28 = 32'sd421657428;

    // Heading selection codes decided by the front end
    typedef enum logic [1:0] {
        H_ZERO  = 2'd0,
        H_CONST = 2'd1,
        H_NEG   = 2'd2,
        H_POS   = 2'd3
    } t_hmode;

    typedef enum logic [1:0] {
        P_ZERO  = 2'd0,
        P_CONST = 2'd1,
        P_CORD  = 2'd2
    } t_pmode;

    // Classified item handed from front to back
    typedef struct packed {
        t_hmode             hmode;
        t_pmode             pmode;
        logic signed [31:0] hconst;
        logic signed [31:0] pconst;
        logic signed [32:0] hn;   // heading atan2 numerator
        logic        [32:0] hd;   // heading atan2 denominator (>= 0)
        logic signed [31:0] y;
        logic        [65:0] sq_sum;
    } t_cls;

    function automatic logic signed [31:0] atan_q30(input int i);
        logic signed [31:0] r;
        unique case (i)
            0: r = 32'sd843314856;   1: r = 32'sd497837829;
            2: r = 32'sd263043836;   3: r = 32'sd133525158;
            4: r = 32'sd67021686;    5: r = 32'sd33543515;
            6: r = 32'sd16775850;    7: r = 32'sd8388437;
            8: r = 32'sd4194282;     9: r = 32'sd2097149;
            10: r = 32'sd1048575;    11: r = 32'sd524287;
            12: r = 32'sd262143;     13: r = 32'sd131071;
            14: r = 32'sd65535;      15: r = 32'sd32767;
            16: r = 32'sd16383;      17: r = 32'sd8191;
            18: r = 32'sd4095;       19: r = 32'sd2047;
            20: r = 32'sd1023;       21: r = 32'sd511;
            22: r = 32'sd255;        23: r = 32'sd127;
            24: r = 32'sd63;         25: r = 32'sd31;
            26: r = 32'sd15;         27: r = 32'sd7;
            28: r = 32'sd3;          29: r = 32'sd1;
            default: r = 32'sd0;
        endcase
        return r;
    endfunction
endpackage

[hw/rtl/hpv_if.sv]
// Valid/ready channel interfaces for vectors, angles and the epsilon register.
`timescale 1ns / 1ps
interface hpv_vec_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] dir_x;
    logic signed [31:0] dir_y;
    logic signed [31:0] dir_z;
    modport source  (output valid, dir_x, dir_y, dir_z, input ready);
    modport sink    (input valid, dir_x, dir_y, dir_z, output ready);
    modport monitor (input valid, ready, dir_x, dir_y, dir_z);
endinterface

interface hpv_ang_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] heading;
    logic signed [31:0] pitch;
    modport source  (output valid, heading, pitch, input ready);
    modport sink    (input valid, heading, pitch, output ready);
    modport monitor (input valid, ready, heading, pitch);
endinterface

interface hpv_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] zero_epsilon;
    modport source  (output valid, zero_epsilon, input ready);
    modport sink    (input valid, zero_epsilon, output ready);
    modport monitor (input valid, ready, zero_epsilon);
endinterface

[hw/rtl/hpv_front.sv]
// Front end: zero tests, case classification and the squared hypotenuse.
`timescale 1ns / 1ps
module hpv_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic signed [31:0] i_x,
    input  logic signed [31:0] i_y,
    input  logic signed [31:0] i_z,
    input  logic [15:0]        i_eps,
    output logic               o_valid,
    input  logic               i_ready,
    output hpv_pkg::t_cls      o_cls
);
    // stage 1: magnitudes and zero tests; stage 2: squares (32x32 each) and class
    logic               r_v1, r_v2;
    logic [31:0]        r_ax, r_az;
    logic               r_zx, r_zz, r_zy;
    logic signed [31:0] r_x, r_y, r_z;
    hpv_pkg::t_cls      r_cls;
    logic               adv1, adv2;
    logic               zx, zy, zz;
    logic [31:0]        ax, ay, az;
    logic [63:0]        sq_x, sq_z;
    hpv_pkg::t_cls      n_cls;

    assign ax = i_x[31] ? 32'(-i_x) : 32'(i_x);
    assign ay = i_y[31] ? 32'(-i_y) : 32'(i_y);
    assign az = i_z[31] ? 32'(-i_z) : 32'(i_z);
    assign zx = (i_x == 0) || (ax < {16'd0, i_eps});
    assign zy = (i_y == 0) || (ay < {16'd0, i_eps});
    assign zz = (i_z == 0) || (az < {16'd0, i_eps});

    assign sq_x = r_ax * r_ax;
    assign sq_z = r_az * r_az;

    assign adv2   = !r_v2 || i_ready;
    assign adv1   = !r_v1 || adv2;
    assign o_ready = adv1;
    assign o_valid = r_v2;
    assign o_cls   = r_cls;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (adv1) r_v1 <= i_valid;
            if (adv2) r_v2 <= r_v1;
        end
        if (adv1 && i_valid) begin
            r_ax <= ax; r_az <= az;
            r_zx <= zx; r_zy <= zy; r_zz <= zz;
            r_x <= i_x; r_y <= i_y; r_z <= i_z;
        end
        if (adv2 && r_v1) r_cls <= n_cls;
    end

    always_comb begin
        n_cls = '0;
        n_cls.y      = r_y;
        n_cls.sq_sum = 66'(sq_x) + 66'(sq_z);
        if (r_zx && r_zz) begin
            n_cls.hmode = hpv_pkg::H_ZERO;
            if (r_zy) begin
                n_cls.pmode = hpv_pkg::P_ZERO;
            end else begin
                n_cls.pmode  = hpv_pkg::P_CONST;
                n_cls.pconst = r_y[31] ? -hpv_pkg::PI_DIV_2_Q28 : hpv_pkg::PI_DIV_2_Q28;
            end
        end else begin
            n_cls.pmode = hpv_pkg::P_CORD;
            if (r_zz) begin
                n_cls.hmode  = hpv_pkg::H_CONST;
                n_cls.hconst = (!r_x[31] && r_x != 0) ? -hpv_pkg::PI_DIV_2_Q28
                                                      : hpv_pkg::PI_DIV_2_Q28;
            end else if (r_z[31]) begin
                n_cls.hmode = hpv_pkg::H_NEG;
                n_cls.hn    = -33'(r_x);
                n_cls.hd    = 33'(r_az);
            end else begin
                n_cls.hmode = hpv_pkg::H_POS;
                n_cls.hn    = 33'(r_x);
                n_cls.hd    = 33'(r_az);
            end
        end
    end
endmodule

[hw/rtl/hpv_fifo.sv]
// Short skid queue between front and back end.
`timescale 1ns / 1ps
module hpv_fifo #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [WIDTH-1:0] o_data
);
    logic [WIDTH-1:0] r_mem [2];
    logic             r_wp, r_rp;
    logic [1:0]       r_cnt;
    logic             wr, rd;
    assign o_ready = r_cnt != 2'd2;
    assign o_valid = r_cnt != 2'd0;
    assign o_data  = r_mem[r_rp];
    assign wr = i_valid && o_ready;
    assign rd = o_valid && i_ready;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= 2'd0;
        end else begin
            if (wr) r_wp <= !r_wp;
            if (rd) r_rp <= !r_rp;
            r_cnt <= r_cnt + 2'(wr) - 2'(rd);
        end
        if (wr) r_mem[r_wp] <= i_data;
    end
endmodule

[hw/rtl/hpv_back.sv]
// Back end: pipelined square root, then two CORDIC pipelines and result register.
`timescale 1ns / 1ps
module hpv_back #(
    parameter int CORDIC_STAGES = 28
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  hpv_pkg::t_cls      i_cls,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [31:0] o_heading,
    output logic signed [31:0] o_pitch
);
    localparam int SQ = 33;            // one result bit per stage
    // input register, root stages, CORDIC load, CORDIC stages, result register
    localparam int NS = SQ + CORDIC_STAGES + 2;
    localparam int AW = 34;            // angle accumulator, Q2.30 plus headroom

    typedef struct packed {
        hpv_pkg::t_hmode    hmode;
        hpv_pkg::t_pmode    pmode;
        logic signed [31:0] hconst;
        logic signed [31:0] pconst;
    } t_tag;

    logic adv;
    logic [NS:0] r_v;
    assign adv = !r_v[NS] || i_ready;
    assign o_ready = adv;
    assign o_valid = r_v[NS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v <= '0;
        else if (adv) r_v <= {r_v[NS-1:0], i_valid};
    end

    // square root section: restoring, one bit per stage
    logic [65:0]        r_rem [SQ+1];
    logic [32:0]        r_root[SQ+1];
    t_tag               r_tag [NS+1];
    logic signed [32:0] r_hn0 [SQ+1];
    logic [32:0]        r_hd0 [SQ+1];
    logic signed [31:0] r_y0  [SQ+1];

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_rem[0]  <= i_cls.sq_sum;
            r_root[0] <= '0;
            r_hn0[0]  <= i_cls.hn;
            r_hd0[0]  <= i_cls.hd;
            r_y0[0]   <= i_cls.y;
            r_tag[0]  <= '{i_cls.hmode, i_cls.pmode, i_cls.hconst, i_cls.pconst};
            for (int k = 0; k < NS; k++) r_tag[k+1] <= r_tag[k];
        end
    end

    for (genvar s = 0; s < SQ; s++) begin : g_sq
        localparam int B = SQ - 1 - s;
        logic [67:0] trial;
        assign trial = ({2'b0, r_root[s]} << (B + 1)) + (68'd1 << (2 * B));
        always_ff @(posedge i_clk) begin
            if (adv) begin
                if (68'(r_rem[s]) >= trial) begin
                    r_rem[s+1]  <= 66'(68'(r_rem[s]) - trial);
                    r_root[s+1] <= r_root[s] | (33'd1 << B);
                end else begin
                    r_rem[s+1]  <= r_rem[s];
                    r_root[s+1] <= r_root[s];
                end
                r_hn0[s+1] <= r_hn0[s];
                r_hd0[s+1] <= r_hd0[s];
                r_y0[s+1]  <= r_y0[s];
            end
        end
    end

    // CORDIC section: two lanes, heading and pitch, in lockstep
    logic signed [63:0] r_hx [CORDIC_STAGES+1], r_hy [CORDIC_STAGES+1];
    logic signed [63:0] r_px [CORDIC_STAGES+1], r_py [CORDIC_STAGES+1];
    logic signed [AW-1:0] r_ha [CORDIC_STAGES+1], r_pa [CORDIC_STAGES+1];

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_hx[0] <= 64'(r_hd0[SQ]) <<< 24;
            r_hy[0] <= 64'(r_hn0[SQ]) <<< 24;
            r_px[0] <= 64'(r_root[SQ]) <<< 24;
            r_py[0] <= 64'(r_y0[SQ]) <<< 24;
            r_ha[0] <= '0;
            r_pa[0] <= '0;
        end
    end

    for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cor
        logic signed [AW-1:0] t;
        assign t = AW'(hpv_pkg::atan_q30(i));
        always_ff @(posedge i_clk) begin
            if (adv) begin
                if (!r_hy[i][63]) begin
                    r_hx[i+1] <= r_hx[i] + (r_hy[i] >>> i);
                    r_hy[i+1] <= r_hy[i] - (r_hx[i] >>> i);
                    r_ha[i+1] <= r_ha[i] + t;
                end else begin
                    r_hx[i+1] <= r_hx[i] - (r_hy[i] >>> i);
                    r_hy[i+1] <= r_hy[i] + (r_hx[i] >>> i);
                    r_ha[i+1] <= r_ha[i] - t;
                end
                if (!r_py[i][63]) begin
                    r_px[i+1] <= r_px[i] + (r_py[i] >>> i);
                    r_py[i+1] <= r_py[i] - (r_px[i] >>> i);
                    r_pa[i+1] <= r_pa[i] + t;
                end else begin
                    r_px[i+1] <= r_px[i] - (r_py[i] >>> i);
                    r_py[i+1] <= r_py[i] + (r_px[i] >>> i);
                    r_pa[i+1] <= r_pa[i] - t;
                end
            end
        end
    end

    // final stage: round to Q4.28 and select by case
    logic signed [AW-1:0] ha, pa;
    logic signed [31:0]   h_at, p_at;
    t_tag                 tg;
    logic signed [31:0]   r_h, r_p;
    assign ha   = (r_ha[CORDIC_STAGES] + AW'(2)) >>> 2;
    assign pa   = (r_pa[CORDIC_STAGES] + AW'(2)) >>> 2;
    assign h_at = ha[31:0];
    assign p_at = pa[31:0];
    assign tg   = r_tag[NS-1];

    always_ff @(posedge i_clk) begin
        if (adv) begin
            unique case (tg.hmode)
                hpv_pkg::H_ZERO:  r_h <= '0;
                hpv_pkg::H_CONST: r_h <= tg.hconst;
                hpv_pkg::H_NEG:   r_h <= hpv_pkg::PI_Q28 - h_at;
                hpv_pkg::H_POS:   r_h <= -h_at;
                default:          r_h <= '0;
            endcase
            unique case (tg.pmode)
                hpv_pkg::P_CONST: r_p <= tg.pconst;
                hpv_pkg::P_CORD:  r_p <= p_at;
                default:          r_p <= '0;
            endcase
        end
    end
    assign o_heading = r_h;
    assign o_pitch   = r_p;
endmodule

[hw/rtl/heading_pitch_from_vector.sv]
// Top level: heading and pitch angles from a direction vector.
// Path: front, skid queue, input reg, 33 root stages, CORDIC load and stages, result reg.
// Throughput: one vector per cycle unless stalled; both CORDIC lanes and root fully pipelined.
// Backpressure stalls the back pipeline as a whole; the queue decouples the front.
// Reset (synchronous, active low) empties all stages; zero_epsilon returns to 1.
`timescale 1ns / 1ps
module heading_pitch_from_vector #(
    parameter int CORDIC_STAGES = 28
) (
    input logic    i_clk,
    input logic    i_rst_n,
    hpv_cfg_if.sink   cfg,
    hpv_vec_if.sink   vec_in,
    hpv_ang_if.source ang_out
);
    logic [15:0]   r_eps;
    logic          f_v, f_r, q_v, q_r;
    hpv_pkg::t_cls f_cls, q_cls;

    assign cfg.ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_eps <= 16'd1;
        else if (cfg.valid) r_eps <= cfg.zero_epsilon;
    end

    hpv_front u_front (
        .i_clk, .i_rst_n,
        .i_valid(vec_in.valid), .o_ready(vec_in.ready),
        .i_x(vec_in.dir_x), .i_y(vec_in.dir_y), .i_z(vec_in.dir_z),
        .i_eps(r_eps),
        .o_valid(f_v), .i_ready(f_r), .o_cls(f_cls)
    );

    hpv_fifo #(.WIDTH($bits(hpv_pkg::t_cls))) u_q (
        .i_clk, .i_rst_n,
        .i_valid(f_v), .o_ready(f_r), .i_data(f_cls),
        .o_valid(q_v), .i_ready(q_r), .o_data(q_cls)
    );

    hpv_back #(.CORDIC_STAGES(CORDIC_STAGES)) u_back (
        .i_clk, .i_rst_n,
        .i_valid(q_v), .o_ready(q_r), .i_cls(q_cls),
        .o_valid(ang_out.valid), .i_ready(ang_out.ready),
        .o_heading(ang_out.heading), .o_pitch(ang_out.pitch)
    );
endmodule

[hw/rtl/hpv_checker.sv]
// Port-level checker for the heading/pitch block, bound to the top level.
`timescale 1ns / 1ps
module hpv_port_props (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_valid,
    input logic               i_ready,
    input logic signed [31:0] o_heading,
    input logic signed [31:0] o_pitch
);
    // bounds carry a small margin for CORDIC residual and table truncation
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_heading) && $stable(o_pitch))
        else $error("result dropped under stall");
    a_prange: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_pitch <= 32'sd421657684 && o_pitch >= -32'sd421657684)
        else $error("pitch out of range");
    a_hrange: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_heading >= -32'sd421657684 && o_heading <= 32'sd1264972541)
        else $error("heading out of range");
    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("valid after reset");
endmodule

bind heading_pitch_from_vector hpv_port_props u_chk (
    .i_clk, .i_rst_n,
    .o_valid(ang_out.valid), .i_ready(ang_out.ready),
    .o_heading(ang_out.heading), .o_pitch(ang_out.pitch)
);

[tb/hpv_checker.sv]
// Checker: watches the channels, predicts heading/pitch and compares each output beat.
`timescale 1ns / 1ps
module hpv_checker #(
    parameter int CORDIC_STAGES = 28
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    hpv_cfg_if.monitor  cfg_mon,
    hpv_vec_if.monitor  vec_mon,
    hpv_ang_if.monitor  ang_mon,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_results
);
    typedef struct {
        logic signed [31:0] heading;
        logic signed [31:0] pitch;
    } t_angles;

    t_angles     angle_queue[$];
    logic [15:0] eps_shadow;

    function automatic logic signed [63:0] shr_floor(logic signed [63:0] v, int s);
        return v >>> s;
    endfunction

    function automatic bit is_small(logic signed [63:0] v, logic [15:0] eps);
        logic [63:0] m;
        m = (v < 0) ? -v : v;
        return (v == 0) || (m < {48'd0, eps});
    endfunction

    function automatic logic [63:0] int_sqrt(logic [63:0] v);
        logic [63:0] res;
        logic [63:0] bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // vectoring rotation, d >= 0, angle returned in Q4.28
    function automatic logic signed [63:0] vec_atan(logic signed [63:0] n,
                                                     logic signed [63:0] d);
        logic signed [63:0] xr, yr, ang, xs, ys;
        logic signed [63:0] tab[32];
        tab = '{843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
                16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143,
                131071, 65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255,
                127, 63, 31, 15, 7, 3, 1, 0, 0};
        xr = d <<< 24;
        yr = n <<< 24;
        ang = 0;
        for (int i = 0; i < CORDIC_STAGES && i < 32; i++) begin
            xs = shr_floor(xr, i);
            ys = shr_floor(yr, i);
            if (yr >= 0) begin
                xr = xr + ys; yr = yr - xs; ang = ang + tab[i];
            end else begin
                xr = xr - ys; yr = yr + xs; ang = ang - tab[i];
            end
        end
        return shr_floor(ang + 2, 2);
    endfunction

    function automatic t_angles predict_angles(logic signed [31:0] dx,
                                               logic signed [31:0] dy,
                                               logic signed [31:0] dz,
                                               logic [15:0] eps);
        t_angles r;
        logic signed [63:0] x, y, z, h, p, hyp;
        logic [63:0] ax, az;
        x = dx; y = dy; z = dz;
        if (is_small(x, eps) && is_small(z, eps)) begin
            h = 0;
            if (is_small(y, eps)) p = 0;
            else p = (y > 0) ? hpv_pkg::PI_DIV_2_Q28 : -hpv_pkg::PI_DIV_2_Q28;
        end else begin
            ax = (x < 0) ? -x : x;
            az = (z < 0) ? -z : z;
            hyp = int_sqrt(ax * ax + az * az);
            if (is_small(z, eps))
                h = (x > 0) ? -hpv_pkg::PI_DIV_2_Q28 : hpv_pkg::PI_DIV_2_Q28;
            else if (z < 0) h = hpv_pkg::PI_Q28 - vec_atan(-x, -z);
            else h = -vec_atan(x, z);
            p = vec_atan(y, hyp);
        end
        r.heading = h[31:0];
        r.pitch = p[31:0];
        return r;
    endfunction

    assign o_pending = angle_queue.size();

    always @(posedge i_clk) begin
        t_angles want;
        if (!i_rst_n) begin
            eps_shadow <= 16'd1;
            angle_queue.delete();
            o_fail_count <= 0;
            o_results <= 0;
        end else begin
            if (vec_mon.valid && vec_mon.ready)
                angle_queue.push_back(predict_angles(vec_mon.dir_x, vec_mon.dir_y,
                                                     vec_mon.dir_z, eps_shadow));
            if (cfg_mon.valid && cfg_mon.ready)
                eps_shadow <= cfg_mon.zero_epsilon;
            if (ang_mon.valid && ang_mon.ready) begin
                o_results <= o_results + 1;
                if (angle_queue.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("unexpected beat: heading %0d pitch %0d",
                                 ang_mon.heading, ang_mon.pitch);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = angle_queue.pop_front();
                    if (want.heading !== ang_mon.heading || want.pitch !== ang_mon.pitch)
                    begin
                        if (o_fail_count < 10)
                            $display("mismatch: heading exp %0d got %0d, pitch exp %0d got %0d",
                                     want.heading, ang_mon.heading, want.pitch,
                                     ang_mon.pitch);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

[tb/tb.sv]
// Testbench top: drives vectors and epsilon settings, throttles output, reports verdict.
`timescale 1ns / 1ps
module tb;
    localparam int LATENCY = 2 + 1 + 33 + 28 + 2;
    localparam int WATCHDOG = 5000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    hpv_cfg_if cfg();
    hpv_vec_if vec();
    hpv_ang_if ang();

    int fail_count, pending, results;
    int idle_pct = 23;
    bit hold_sink = 1'b0;
    bit done = 1'b0;
    int quiet_cycles = 0;

    always #2 i_clk = ~i_clk;

    heading_pitch_from_vector dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .cfg(cfg), .vec_in(vec), .ang_out(ang)
    );

    hpv_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .cfg_mon(cfg), .vec_mon(vec), .ang_mon(ang),
        .o_fail_count(fail_count), .o_pending(pending), .o_results(results)
    );

    initial begin
        cfg.valid = 1'b0; cfg.zero_epsilon = '0;
        vec.valid = 1'b0; vec.dir_x = '0; vec.dir_y = '0; vec.dir_z = '0;
        ang.ready = 1'b0;
    end

    // output side throttling
    always @(negedge i_clk) begin
        if (!i_rst_n || hold_sink) ang.ready <= 1'b0;
        else ang.ready <= ($urandom_range(99) >= idle_pct);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (vec.valid && vec.ready) || (ang.valid && ang.ready)
            || (cfg.valid && cfg.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > WATCHDOG && !done) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // valid stays high between back-to-back beats; drain() drops it
    task automatic send_vec(logic signed [31:0] x, logic signed [31:0] y,
                            logic signed [31:0] z);
        while ($urandom_range(99) < idle_pct) begin
            vec.valid <= 1'b0;
            @(negedge i_clk);
        end
        vec.valid <= 1'b1; vec.dir_x <= x; vec.dir_y <= y; vec.dir_z <= z;
        @(posedge i_clk);
        while (!vec.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic drain();
        vec.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (LATENCY + 4) @(negedge i_clk);
    endtask

    task automatic write_eps(logic [15:0] e);
        drain();
        cfg.valid <= 1'b1; cfg.zero_epsilon <= e;
        @(posedge i_clk);
        while (!cfg.ready) @(posedge i_clk);
        @(negedge i_clk);
        cfg.valid <= 1'b0;
    endtask

    function automatic logic signed [31:0] rnd_comp(logic [15:0] eps);
        case ($urandom_range(9))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return 0;
            3: return $signed($urandom_range(2 * eps + 2)) - $signed({16'd0, eps}) - 1;
            4: return $signed($urandom_range(255)) - 128;
            5: return $signed($urandom) >>> $urandom_range(31);
            default: return $urandom;
        endcase
    endfunction

    initial begin
        logic signed [31:0] lim[4];
        logic [15:0] eps_list[5];
        logic [15:0] eps;
        int n;
        lim = '{32'sh7fffffff, 32'sh80000000, 0, 1};
        eps_list = '{16'd1, 16'd0, 16'hffff, 16'd300, 16'd7};
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes, null, vertical, zero z, both z signs
        foreach (lim[a]) foreach (lim[b]) send_vec(lim[a], lim[b], lim[(a + b) % 4]);
        send_vec(0, 0, 0);
        send_vec(0, 65536, 0);
        send_vec(0, -65536, 0);
        send_vec(65536, 5, 0);
        send_vec(-65536, -5, 0);
        send_vec(3, 3, -70000);
        send_vec(-3, 3, 70000);
        send_vec(1, -1, -1);

        // long receiver hold-off while input keeps coming
        hold_sink = 1'b1;
        fork
            begin repeat (400) @(negedge i_clk); hold_sink = 1'b0; end
            begin
                repeat (150) send_vec($urandom, $urandom, $urandom);
            end
        join

        n = 0;
        foreach (eps_list[k]) begin
            eps = eps_list[k];
            write_eps(eps);
            idle_pct = (k == 2) ? 0 : 23;
            repeat (360) begin
                send_vec(rnd_comp(eps), rnd_comp(eps), rnd_comp(eps));
                n++;
                if (n % 500 == 0) drain();
            end
        end

        drain();
        done = 1'b1;
        $display("Sent directed and random vectors over 5 epsilon settings (0, 1, 7, 300, 65535);");
        $display("%0d result beats checked, with backpressure and full stall periods.", results);
        if (fail_count == 0) $display("TB_OK");
        else $display("TB_ERROR");
        $finish;
    end
endmodule

[heading_pitch_from_vector.f]
hw/rtl/hpv_pkg.sv
hw/rtl/hpv_if.sv
hw/rtl/hpv_front.sv
hw/rtl/hpv_fifo.sv
hw/rtl/hpv_back.sv
hw/rtl/heading_pitch_from_vector.sv
hw/rtl/hpv_checker.sv
tb/hpv_checker.sv
tb/tb.sv
